### src/pct_pkg.sv
// ----------------------------------------------------------------------------
// Percent-escape decoder package
// Item types, escape phase codes, character constants and the hex digit
// decode shared by the channel interfaces and the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

   // Characters that the decoder recognizes.
   localparam logic [7:0] PCT_CHAR   = 8'h25;  // '%'
   localparam logic [7:0] DIG0_CHAR  = 8'h30;  // '0'
   localparam logic [7:0] DIG9_CHAR  = 8'h39;  // '9'
   localparam logic [7:0] LOWA_CHAR  = 8'h61;  // 'a'
   localparam logic [7:0] LOWF_CHAR  = 8'h66;  // 'f'
   localparam logic [7:0] UPA_CHAR   = 8'h41;  // 'A'
   localparam logic [7:0] UPF_CHAR   = 8'h46;  // 'F'

   // Most result items that one input item can cause.
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

   // Escape progress between input items.
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,  // no escape pending
      PH_PCT   = 2'd1,  // '%' seen
      PH_DIGIT = 2'd2   // '%' and one hex digit seen
   } phase_type;

   // One encoded input item.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } req_item_type;

   // One decoded result item.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } rsp_item_type;

   // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= DIG0_CHAR && c <= DIG9_CHAR) begin
         d = c - DIG0_CHAR;
         return {1'b1, d[3:0]};
      end else if (c >= LOWA_CHAR && c <= LOWF_CHAR) begin
         d = c - LOWA_CHAR + 8'd10;
         return {1'b1, d[3:0]};
      end else if (c >= UPA_CHAR && c <= UPF_CHAR) begin
         d = c - UPA_CHAR + 8'd10;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

`default_nettype wire

### src/pct_req_if.sv
// ----------------------------------------------------------------------------
// Encoded byte channel
// Valid/ready channel that carries one encoded input item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pct_req_if
   import pct_pkg::*;
();
   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

### src/pct_rsp_if.sv
// ----------------------------------------------------------------------------
// Decoded byte channel
// Valid/ready channel that carries one decoded result item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pct_rsp_if
   import pct_pkg::*;
();
   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

### src/percent_escape_decoder.sv
// ----------------------------------------------------------------------------
// Percent-escape decoder
//
//   Channel    Dir   Item fields                        Handshake
//   req_chan   in    in_byte[7:0], is_last              valid/ready
//   rsp_chan   out   out_byte[7:0], run_last, stream_end valid/ready
//
// An input item is decoded in the cycle it is accepted and its zero to three
// result items land in the result buffer; results leave one per cycle while
// rsp_chan.ready is high. A new item is taken whenever the buffer is empty
// or its last result is taken in the same cycle, so plain bytes flow at one
// item per cycle unless rsp_chan stalls. An escape broken or flushed at
// stream end with two or three results holds req_chan.ready low till drained.
// Reset clears the escape phase and empties the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module percent_escape_decoder
   import pct_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   pct_req_if.sink    req_chan,
   pct_rsp_if.source  rsp_chan
);

   // Escape state carried between input items.
   phase_type        phase_ff, phase_in;
   logic [7:0]       digit_ff, digit_in;

   // Result buffer: bytes, fill count, read position and stream end flag.
   logic [7:0]       byte_ff [MAX_RESULTS];
   logic [7:0]       byte_in [MAX_RESULTS];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             end_ff, end_in;

   // Decoded results of the item at the input.
   logic [7:0]       dec_byte [MAX_RESULTS];
   logic [CNT_W-1:0] dec_cnt;
   phase_type        dec_phase;
   logic [7:0]       dec_digit;

   logic [7:0]       cur_byte;
   logic             cur_last;
   logic             cur_pct;
   logic [4:0]       cur_hex;
   logic [4:0]       held_hex;
   logic             req_fire;
   logic             rsp_fire;
   logic             rsp_is_last;

   assign cur_byte = req_chan.item.in_byte;
   assign cur_last = req_chan.item.is_last;
   assign cur_pct  = (cur_byte == PCT_CHAR);
   assign cur_hex  = hex_nibble(cur_byte);
   assign held_hex = hex_nibble(digit_ff);

   // Decode one item against the current escape phase.
   always_comb begin
      dec_byte[0] = cur_byte;
      dec_byte[1] = cur_byte;
      dec_byte[2] = cur_byte;
      dec_cnt     = '0;
      dec_phase   = PH_IDLE;
      dec_digit   = digit_ff;
      case (phase_ff)
         PH_PCT: begin
            if (cur_pct) begin
               // A doubled '%' stands for itself.
               dec_byte[0] = PCT_CHAR;
               dec_cnt     = CNT_W'(1);
            end else if (cur_hex[4] && !cur_last) begin
               dec_phase = PH_DIGIT;
               dec_digit = cur_byte;
            end else begin
               // Bad digit or end of stream: '%' and the byte as text.
               dec_byte[0] = PCT_CHAR;
               dec_cnt     = CNT_W'(2);
            end
         end
         PH_DIGIT: begin
            if (cur_hex[4]) begin
               dec_byte[0] = {held_hex[3:0], cur_hex[3:0]};
               dec_cnt     = CNT_W'(1);
            end else begin
               // Flush '%' and the held digit, then handle the byte afresh.
               dec_byte[0] = PCT_CHAR;
               dec_byte[1] = digit_ff;
               if (cur_pct && !cur_last) begin
                  dec_cnt   = CNT_W'(2);
                  dec_phase = PH_PCT;
               end else begin
                  dec_cnt = CNT_W'(3);
               end
            end
         end
         default: begin
            if (cur_pct && !cur_last) begin
               dec_phase = PH_PCT;
            end else begin
               dec_cnt = CNT_W'(1);
            end
         end
      endcase
      if (cur_last) begin
         dec_phase = PH_IDLE;
      end
   end

   // Output side of the result buffer.
   assign rsp_is_last              = (idx_ff == cnt_ff - CNT_W'(1));
   assign rsp_chan.valid           = (cnt_ff != '0);
   assign rsp_chan.item.out_byte   = byte_ff[idx_ff[1:0]];
   assign rsp_chan.item.run_last   = rsp_is_last;
   assign rsp_chan.item.stream_end = rsp_is_last & end_ff;
   assign rsp_fire                 = rsp_chan.valid & rsp_chan.ready;

   // Take a new item when the buffer is empty or drains this cycle.
   assign req_chan.ready = (cnt_ff == '0) || (rsp_fire && rsp_is_last);
   assign req_fire       = req_chan.valid & req_chan.ready;

   // Next state of the escape phase and the result buffer.
   always_comb begin
      phase_in = phase_ff;
      digit_in = digit_ff;
      byte_in  = byte_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      end_in   = end_ff;
      if (rsp_fire) begin
         if (rsp_is_last) begin
            cnt_in = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
      if (req_fire) begin
         phase_in = dec_phase;
         digit_in = dec_digit;
         byte_in  = dec_byte;
         cnt_in   = dec_cnt;
         idx_in   = '0;
         end_in   = cur_last;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      byte_ff  <= byte_in;
      end_ff   <= end_in;
   end

`ifndef SYNTHESIS
   // The buffer comes up empty after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result buffer not empty after reset");

   // An item is never taken over results that are still waiting.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (cnt_ff == '0) || (rsp_fire && rsp_is_last))
      else $error("input item accepted over pending results");

   // The read position stays inside the filled part of the buffer.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (idx_ff < cnt_ff))
      else $error("result read position out of range");

   // The end of a stream leaves no escape pending.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && cur_last) |=> (phase_ff == PH_IDLE))
      else $error("escape left pending after final byte");
`endif

endmodule

`default_nettype wire

### test/tb_percent_escape_decoder.sv
// ----------------------------------------------------------------------------
// Percent-escape decoder testbench
// Feeds encoded byte streams to the decoder and checks every decoded item
// against a scoreboard that tracks the escape phase on its own. A short
// directed run covers the escape forms and the end-of-stream flushes. Random
// streams follow: well-formed escapes, plain bytes and doubled percents, with some broken escapes and noise.
// Both channels idle in random bursts until the last part of the run.
// ----------------------------------------------------------------------------
`default_nettype none

// Tracks the escape phase and queues the decoded items that each input causes.
class escape_decode_scoreboard;
   pct_pkg::rsp_item_type expected_bytes[$];
   pct_pkg::phase_type phase;
   logic [7:0]   held_digit;
   int unsigned  error_count;

   function new();
      phase       = pct_pkg::PH_IDLE;
      held_digit  = 8'h00;
      error_count = 0;
   endfunction

   // Value of a hex digit character, or -1 when the character is no digit.
   function int digit_value(logic [7:0] c);
      if (c >= pct_pkg::DIG0_CHAR && c <= pct_pkg::DIG9_CHAR)
         return int'(c - pct_pkg::DIG0_CHAR);
      if (c >= pct_pkg::LOWA_CHAR && c <= pct_pkg::LOWF_CHAR)
         return int'(c - pct_pkg::LOWA_CHAR) + 10;
      if (c >= pct_pkg::UPA_CHAR && c <= pct_pkg::UPF_CHAR)
         return int'(c - pct_pkg::UPA_CHAR) + 10;
      return -1;
   endfunction

   function void emit(logic [7:0] b);
      pct_pkg::rsp_item_type r;
      r.out_byte   = b;
      r.run_last   = 1'b0;
      r.stream_end = 1'b0;
      expected_bytes.push_back(r);
   endfunction

   // A byte seen with no escape open: a percent opens one unless the stream ends.
   function void plain_byte(logic [7:0] b, logic last);
      if (b == pct_pkg::PCT_CHAR) begin
         if (last) begin
            emit(pct_pkg::PCT_CHAR);
            phase = pct_pkg::PH_IDLE;
         end else begin
            phase = pct_pkg::PH_PCT;
         end
      end else begin
         emit(b);
         phase = pct_pkg::PH_IDLE;
      end
   endfunction

   // Works out the decoded items caused by one accepted input item.
   function void predict_byte(pct_pkg::req_item_type it);
      int           first_idx;
      int           lo;
      int           hi;
      logic [7:0]   b;
      logic         last;
      pct_pkg::rsp_item_type tail;
      b         = it.in_byte;
      last      = it.is_last;
      first_idx = expected_bytes.size();
      case (phase)
         pct_pkg::PH_PCT: begin
            if (b == pct_pkg::PCT_CHAR) begin
               emit(pct_pkg::PCT_CHAR);
               phase = pct_pkg::PH_IDLE;
            end else if (digit_value(b) >= 0) begin
               if (last) begin
                  emit(pct_pkg::PCT_CHAR);
                  emit(b);
                  phase = pct_pkg::PH_IDLE;
               end else begin
                  held_digit = b;
                  phase      = pct_pkg::PH_DIGIT;
               end
            end else begin
               emit(pct_pkg::PCT_CHAR);
               plain_byte(b, last);
            end
         end
         pct_pkg::PH_DIGIT: begin
            lo = digit_value(b);
            if (lo >= 0) begin
               hi = digit_value(held_digit);
               if (hi < 0) hi = 0;
               emit(8'((hi << 4) | lo));
               phase = pct_pkg::PH_IDLE;
            end else begin
               emit(pct_pkg::PCT_CHAR);
               emit(held_digit);
               plain_byte(b, last);
            end
         end
         default: begin
            plain_byte(b, last);
         end
      endcase
      if (last) phase = pct_pkg::PH_IDLE;
      // The last item of this input carries the run and stream markers.
      if (expected_bytes.size() > first_idx) begin
         tail            = expected_bytes.pop_back();
         tail.run_last   = 1'b1;
         tail.stream_end = last;
         expected_bytes.push_back(tail);
      end
   endfunction

   // Compares one decoded item with the oldest expected one.
   function void check_decoded(pct_pkg::rsp_item_type got);
      pct_pkg::rsp_item_type want;
      if (expected_bytes.size() == 0) begin
         error_count++;
         $display("%0t: unexpected item: expected none, actual byte=%h run_last=%b end=%b",
                  $time, got.out_byte, got.run_last, got.stream_end);
         return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
          got.stream_end !== want.stream_end) begin
         error_count++;
         $display({"%0t: mismatch: expected byte=%h run_last=%b end=%b,",
                   " actual byte=%h run_last=%b end=%b"},
                  $time, want.out_byte, want.run_last, want.stream_end,
                  got.out_byte, got.run_last, got.stream_end);
      end
   endfunction
endclass

module tb_percent_escape_decoder;
   import pct_pkg::*;

   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned ITEM_TARGET = 480;
   localparam int unsigned CALM_START  = 400;

   logic        clock = 1'b0;
   logic        reset;
   bit          calm;
   int unsigned items_sent;
   int unsigned idle_cycles;

   escape_decode_scoreboard decoded = new();

   pct_req_if req_chan();
   pct_rsp_if rsp_chan();

   percent_escape_decoder i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // Random hex digit in any of the three ranges.
   function automatic logic [7:0] hex_char();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return DIG0_CHAR + 8'(r);
      if (r < 16) return LOWA_CHAR + 8'(r - 10);
      return UPA_CHAR + 8'(r - 16);
   endfunction

   // Character that usually breaks an escape: range neighbors, a percent, or noise.
   function automatic logic [7:0] odd_char();
      case ($urandom_range(0, 7))
         0: return DIG0_CHAR - 8'd1;
         1: return DIG9_CHAR + 8'd1;
         2: return UPA_CHAR - 8'd1;
         3: return UPF_CHAR + 8'd1;
         4: return LOWA_CHAR - 8'd1;
         5: return LOWF_CHAR + 8'd1;
         6: return PCT_CHAR;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offers one input item, after a random gap, and waits until it is taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.item  <= '{in_byte: b, is_last: last};
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      items_sent++;
   endtask

   task automatic send_text(input string s, input logic last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], last && (i == s.len() - 1));
   endtask

   // Holds the sender off until every expected item has come out.
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (decoded.expected_bytes.size() != 0) @(posedge clock);
   endtask

   // One stream of random tokens; the final byte carries the stream end.
   task automatic send_random_stream();
      logic [7:0] text[$];
      int         tokens;
      int         kind;
      tokens = $urandom_range(1, 12);
      for (int t = 0; t < tokens; t++) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            text.push_back(PCT_CHAR);
            text.push_back(hex_char());
            text.push_back(hex_char());
         end else if (kind < 65) begin
            text.push_back(8'($urandom_range(0, 255)));
            if (text[$] == PCT_CHAR) text[$] = PCT_CHAR - 8'd1;
         end else if (kind < 75) begin
            text.push_back(PCT_CHAR);
            text.push_back(PCT_CHAR);
         end else if (kind < 83) begin
            text.push_back(PCT_CHAR);
            text.push_back(odd_char());
         end else if (kind < 90) begin
            text.push_back(PCT_CHAR);
            text.push_back(hex_char());
            text.push_back(odd_char());
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      // Sometimes the stream ends inside an escape.
      if ($urandom_range(0, 3) == 0) begin
         text.push_back(PCT_CHAR);
         if ($urandom_range(0, 1) == 1) text.push_back(hex_char());
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   // Result side: ready drops in random bursts until the calm part of the run.
   initial begin
      int stall;
      stall          = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) stall--;
         else if (!calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 8);
         rsp_chan.ready <= (stall == 0);
      end
   end

   // Both handshakes are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) decoded.predict_byte(req_chan.item);
         if (rsp_chan.valid && rsp_chan.ready) decoded.check_decoded(rsp_chan.item);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // Ends the run when nothing has moved for too long.
   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Main sequence: reset, directed streams, random streams, final drain.
   initial begin
      reset          = 1'b1;
      calm           = 1'b0;
      items_sent     = 0;
      idle_cycles    = 0;
      req_chan.valid = 1'b0;
      req_chan.item  = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Byte extremes, good escapes in both cases, a doubled percent, a bad
      // second character, a percent that breaks an escape and opens a new one,
      // a bad third character, and flushes of open escapes at stream end.
      send_byte(8'h00, 1'b0);
      send_text("%41%fF%%%z%4%20%9g", 1'b0);
      send_text("%", 1'b1);
      send_text("%a", 1'b1);
      send_text("%Bq", 1'b1);
      send_byte(8'hFF, 1'b1);
      drain();

      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= CALM_START) calm = 1'b1;
         send_random_stream();
         if ($urandom_range(0, 9) == 0) drain();
      end
      drain();
      repeat (10) @(posedge clock);

      if (decoded.error_count == 0 && decoded.expected_bytes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
